@@ rtl/peer_trust_table_defines.svh @@
// ----------------------------------------------------------------------------
// Peer trust table assertion macros
// Shared concurrent assertion forms, clocked on clock and gated by reset.
// ----------------------------------------------------------------------------
`ifndef PEER_TRUST_TABLE_DEFINES_SVH
`define PEER_TRUST_TABLE_DEFINES_SVH

// Property that holds at every edge outside reset.
`define PTT_ASSERT_ALWAYS(name, prop) \
   name: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("peer_trust_table assertion failed");

// Implication in the same cycle.
`define PTT_ASSERT_IMPL(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("peer_trust_table assertion failed");

`endif

@@ rtl/ptt_pkg.sv @@
// ----------------------------------------------------------------------------
// Peer trust table package
// Sizes, codes and payload types shared by the peer trust table modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ptt_pkg;

   localparam int MAX_PEERS = 64;
   localparam int IDX_W     = $clog2(MAX_PEERS);
   localparam int CNT_W     = $clog2(MAX_PEERS + 1);
   localparam int CSR_IDX_W = 1;
   localparam int CSR_W     = 16;

   localparam logic [2:0] MODE_REGISTER = 3'd0;
   localparam logic [2:0] MODE_LOOKUP   = 3'd1;
   localparam logic [2:0] MODE_BEST     = 3'd2;
   localparam logic [2:0] MODE_DECAY    = 3'd3;
   localparam logic [2:0] MODE_CLEAR    = 3'd4;

   localparam logic [2:0] ST_INSERTED = 3'd0;
   localparam logic [2:0] ST_UPDATED  = 3'd1;
   localparam logic [2:0] ST_EVICTED  = 3'd2;
   localparam logic [2:0] ST_REJECTED = 3'd3;
   localparam logic [2:0] ST_FOUND    = 3'd4;
   localparam logic [2:0] ST_NONE     = 3'd5;

   localparam logic [CSR_IDX_W-1:0] CSR_FRESH_WINDOW = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DECAY_FACTOR = 1'd1;

   localparam logic [15:0] FRESH_WINDOW_RESET = 16'd30;
   localparam logic [15:0] DECAY_FACTOR_RESET = 16'd64881;

   typedef struct packed {
      logic [2:0]  mode;
      logic [63:0] peer_id_high;
      logic [63:0] peer_id_low;
      logic [31:0] peer_address;
      logic [15:0] peer_port;
      logic [15:0] peer_trust;
      logic [31:0] peer_seen_time;
      logic [31:0] now_time;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [63:0] out_id_high;
      logic [63:0] out_id_low;
      logic [31:0] out_address;
      logic [15:0] out_port;
      logic [15:0] out_trust;
      logic [31:0] out_seen_time;
      logic [6:0]  entry_count;
   } rsp_type;

   typedef struct packed {
      logic [63:0] id_high;
      logic [63:0] id_low;
      logic [31:0] address;
      logic [15:0] port;
      logic [15:0] trust;
      logic [31:0] seen;
   } entry_type;

   typedef struct packed {
      logic load;
      logic scan;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic scan_done;
   } sts_type;

endpackage

@@ rtl/ptt_ram.sv @@
// ----------------------------------------------------------------------------
// Peer trust table RAM
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/ptt_ctrl.sv @@
// ----------------------------------------------------------------------------
// Peer trust table controller
// Sequences accept, table scan, commit and response for each transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptt_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   input  ptt_pkg::sts_type sts,
   output ptt_pkg::cmd_type cmd
);
   import ptt_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_SCAN   = 4'b0010,
      S_COMMIT = 4'b0100,
      S_RESP   = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_SCAN;
         end
         S_SCAN: begin
            if (sts.scan_done) state_in = S_COMMIT;
         end
         S_COMMIT: state_in = S_RESP;
         S_RESP: begin
            if (!rsp_stall) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall  = (state_ff != S_IDLE);
   assign rsp_valid  = (state_ff == S_RESP);
   assign cmd.load   = (state_ff == S_IDLE) && req_valid;
   assign cmd.scan   = (state_ff == S_SCAN);
   assign cmd.commit = (state_ff == S_COMMIT);

endmodule

@@ rtl/ptt_datapath.sv @@
// ----------------------------------------------------------------------------
// Peer trust table datapath
// Entry memory, valid bits, scan trackers, decay write-back and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "peer_trust_table_defines.svh"

module ptt_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  ptt_pkg::req_type                  req_data,
   output ptt_pkg::rsp_type                  rsp_data,
   input  logic                              csr_wr_en,
   input  logic [ptt_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ptt_pkg::CSR_W-1:0]         csr_wr_data,
   input  ptt_pkg::cmd_type                  cmd,
   output ptt_pkg::sts_type                  sts
);
   import ptt_pkg::*;

   localparam int EW = $bits(entry_type);

   logic [15:0]          fresh_ff, decay_ff;
   req_type              req_ff;
   rsp_type              rsp_ff, rsp_in;
   logic [MAX_PEERS-1:0] valid_ff, valid_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     rd_idx_ff, rd_idx_in;
   logic                 pend_ff, pend_in;
   logic [IDX_W-1:0]     pend_idx_ff, pend_idx_in;

   logic                 match_hit_ff, match_hit_in;
   logic [IDX_W-1:0]     match_idx_ff, match_idx_in;
   logic                 free_hit_ff, free_hit_in;
   logic [IDX_W-1:0]     free_idx_ff, free_idx_in;
   logic                 min_hit_ff, min_hit_in;
   logic [IDX_W-1:0]     min_idx_ff, min_idx_in;
   logic [15:0]          min_trust_ff, min_trust_in;
   logic                 sel_hit_ff, sel_hit_in;
   entry_type            sel_ent_ff, sel_ent_in;

   entry_type            rd_ent, wr_ent;
   logic                 rd_en, wr_en;
   logic [IDX_W-1:0]     wr_addr;
   logic                 slot_valid, id_match, excl_match, fresh, cand;
   logic [31:0]          age, product;
   logic [31:0]          seen_fix;
   logic                 id_zero, full;
   logic                 cm_wr;
   logic [IDX_W-1:0]     cm_slot;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         fresh_ff <= FRESH_WINDOW_RESET;
         decay_ff <= DECAY_FACTOR_RESET;
      end else if (csr_wr_en) begin
         if (csr_index == CSR_FRESH_WINDOW) fresh_ff <= csr_wr_data;
         if (csr_index == CSR_DECAY_FACTOR) decay_ff <= csr_wr_data;
      end
   end

   // scan read issue
   assign rd_en       = cmd.scan && (rd_idx_ff < CNT_W'(MAX_PEERS));
   assign pend_in     = rd_en;
   assign pend_idx_in = rd_idx_ff[IDX_W-1:0];
   assign rd_idx_in   = cmd.load ? '0 : (rd_en ? rd_idx_ff + 1'b1 : rd_idx_ff);
   assign sts.scan_done = (rd_idx_ff == CNT_W'(MAX_PEERS)) && !pend_ff;

   // per-slot checks on the returned entry
   assign slot_valid = valid_ff[pend_idx_ff];
   assign id_match   = (rd_ent.id_high == req_ff.peer_id_high) &&
                       (rd_ent.id_low == req_ff.peer_id_low);
   assign excl_match = id_match;
   assign age        = req_ff.now_time - rd_ent.seen;
   assign fresh      = (req_ff.now_time >= rd_ent.seen) && (age < {16'd0, fresh_ff});
   assign cand       = slot_valid && !excl_match && fresh;
   assign product    = rd_ent.trust * decay_ff;

   always_comb begin
      match_hit_in = match_hit_ff;
      match_idx_in = match_idx_ff;
      free_hit_in  = free_hit_ff;
      free_idx_in  = free_idx_ff;
      min_hit_in   = min_hit_ff;
      min_idx_in   = min_idx_ff;
      min_trust_in = min_trust_ff;
      sel_hit_in   = sel_hit_ff;
      sel_ent_in   = sel_ent_ff;
      if (cmd.load) begin
         match_hit_in = 1'b0;
         free_hit_in  = 1'b0;
         min_hit_in   = 1'b0;
         sel_hit_in   = 1'b0;
      end else if (pend_ff) begin
         if (slot_valid && id_match && !match_hit_ff) begin
            match_hit_in = 1'b1;
            match_idx_in = pend_idx_ff;
         end
         if (!slot_valid && !free_hit_ff) begin
            free_hit_in = 1'b1;
            free_idx_in = pend_idx_ff;
         end
         if (slot_valid && (!min_hit_ff || rd_ent.trust < min_trust_ff)) begin
            min_hit_in   = 1'b1;
            min_idx_in   = pend_idx_ff;
            min_trust_in = rd_ent.trust;
         end
         if (req_ff.mode == MODE_LOOKUP) begin
            if (slot_valid && id_match && !sel_hit_ff) begin
               sel_hit_in = 1'b1;
               sel_ent_in = rd_ent;
            end
         end else if (cand && (!sel_hit_ff || rd_ent.trust > sel_ent_ff.trust)) begin
            sel_hit_in = 1'b1;
            sel_ent_in = rd_ent;
         end
      end
   end

   // commit decision
   assign id_zero  = (req_ff.peer_id_high == 64'd0) && (req_ff.peer_id_low == 64'd0);
   assign seen_fix = (req_ff.peer_seen_time == 32'd0) ? req_ff.now_time
                                                      : req_ff.peer_seen_time;
   assign full     = (count_ff >= CNT_W'(MAX_PEERS));

   always_comb begin
      rsp_in   = rsp_ff;
      valid_in = valid_ff;
      count_in = count_ff;
      cm_wr    = 1'b0;
      cm_slot  = '0;
      if (cmd.commit) begin
         rsp_in        = '0;
         rsp_in.status = ST_NONE;
         case (req_ff.mode)
            MODE_REGISTER: begin
               rsp_in.status = ST_REJECTED;
               if (!id_zero) begin
                  if (match_hit_ff) begin
                     cm_wr = 1'b1;
                     cm_slot = match_idx_ff;
                     rsp_in.status = ST_UPDATED;
                  end else if (full) begin
                     cm_wr = 1'b1;
                     cm_slot = min_hit_ff ? min_idx_ff : '0;
                     rsp_in.status = ST_EVICTED;
                  end else if (free_hit_ff) begin
                     cm_wr = 1'b1;
                     cm_slot = free_idx_ff;
                     count_in = count_ff + 1'b1;
                     rsp_in.status = ST_INSERTED;
                  end
               end
               if (cm_wr) begin
                  valid_in[cm_slot]    = 1'b1;
                  rsp_in.out_id_high   = req_ff.peer_id_high;
                  rsp_in.out_id_low    = req_ff.peer_id_low;
                  rsp_in.out_address   = req_ff.peer_address;
                  rsp_in.out_port      = req_ff.peer_port;
                  rsp_in.out_trust     = req_ff.peer_trust;
                  rsp_in.out_seen_time = seen_fix;
               end
            end
            MODE_LOOKUP, MODE_BEST: begin
               if (sel_hit_ff) begin
                  rsp_in.status        = ST_FOUND;
                  rsp_in.out_id_high   = sel_ent_ff.id_high;
                  rsp_in.out_id_low    = sel_ent_ff.id_low;
                  rsp_in.out_address   = sel_ent_ff.address;
                  rsp_in.out_port      = sel_ent_ff.port;
                  rsp_in.out_trust     = sel_ent_ff.trust;
                  rsp_in.out_seen_time = sel_ent_ff.seen;
               end
            end
            MODE_CLEAR: begin
               valid_in = '0;
               count_in = '0;
            end
            default: rsp_in.status = ST_NONE;
         endcase
         rsp_in.entry_count = 7'(count_in);
      end
   end

   // write port: decay write-back during the scan, entry store at commit
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = pend_idx_ff;
      wr_ent  = rd_ent;
      if (pend_ff && (req_ff.mode == MODE_DECAY) && slot_valid) begin
         wr_en        = 1'b1;
         wr_ent.trust = product[31:16];
      end else if (cm_wr) begin
         wr_en          = 1'b1;
         wr_addr        = cm_slot;
         wr_ent.id_high = req_ff.peer_id_high;
         wr_ent.id_low  = req_ff.peer_id_low;
         wr_ent.address = req_ff.peer_address;
         wr_ent.port    = req_ff.peer_port;
         wr_ent.trust   = req_ff.peer_trust;
         wr_ent.seen    = seen_fix;
      end
   end

   ptt_ram #(
      .WIDTH (EW),
      .DEPTH (MAX_PEERS)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_ent),
      .rd_en   (rd_en),
      .rd_addr (rd_idx_ff[IDX_W-1:0]),
      .rd_data (rd_ent)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         count_ff  <= '0;
         rd_idx_ff <= '0;
         pend_ff   <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         count_ff  <= count_in;
         rd_idx_ff <= rd_idx_in;
         pend_ff   <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) req_ff <= req_data;
      pend_idx_ff  <= pend_idx_in;
      match_hit_ff <= match_hit_in;
      match_idx_ff <= match_idx_in;
      free_hit_ff  <= free_hit_in;
      free_idx_ff  <= free_idx_in;
      min_hit_ff   <= min_hit_in;
      min_idx_ff   <= min_idx_in;
      min_trust_ff <= min_trust_in;
      sel_hit_ff   <= sel_hit_in;
      sel_ent_ff   <= sel_ent_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_data = rsp_ff;

   `PTT_ASSERT_ALWAYS(a_count_bound, count_ff <= CNT_W'(MAX_PEERS))
   `PTT_ASSERT_ALWAYS(a_count_matches_valid, count_ff == CNT_W'($countones(valid_ff)))
   `PTT_ASSERT_IMPL(a_commit_after_reads, cmd.commit, !pend_ff)

endmodule

@@ rtl/peer_trust_table.sv @@
// Peer trust table: up to 64 peers keyed by a 128-bit id, with register
// (upsert, evicting the lowest-trust entry when full), lookup, best relay,
// decay tick and clear. Every operation walks all slots of the entry memory
// one per cycle, and a transfer occupies the block through accept, the scan
// behind the registered memory read, commit, and a response state that is
// held while the response is stalled. Configuration writes are registered
// and also apply to a transfer in progress.
// ----------------------------------------------------------------------------
// Peer trust table top level
// Joins the sequencing controller and the table datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module peer_trust_table (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  ptt_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output ptt_pkg::rsp_type              rsp_data,
   input  logic                          csr_wr_en,
   input  logic [ptt_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ptt_pkg::CSR_W-1:0]     csr_wr_data
);
   import ptt_pkg::*;

   cmd_type cmd;
   sts_type sts;

   ptt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   ptt_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .sts         (sts)
   );

endmodule
